>>> src/srbm_pkg.sv
// shared types and constants for the slot ring buffer manager
package srbm_pkg;

   // field widths of the request, response and csr port
   localparam int CMD_W      = 3;
   localparam int IDX_W      = 4;
   localparam int TS_W       = 64;
   localparam int CNT_W      = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   // command codes
   localparam logic [CMD_W-1:0] CMD_PUT_ACQUIRE = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUT_DONE    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_GET_ACQUIRE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_GET_DONE    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd4;

   // csr register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LATEST_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERWRITE_EN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_COUNT   = 2'd2;

   // reset value of the slot count register
   localparam logic [CNT_W-1:0] SLOT_COUNT_RESET = 5'd16;

   // per-slot ownership state
   typedef enum logic [1:0] {
      SLOT_FREE    = 2'd0,
      SLOT_WRITING = 2'd1,
      SLOT_FULL    = 2'd2,
      SLOT_READING = 2'd3
   } slot_state_type;

   // sequencer states
   typedef enum logic [3:0] {
      SEQ_IDLE = 4'b0001,
      SEQ_EXEC = 4'b0010,
      SEQ_WALK = 4'b0100,
      SEQ_DONE = 4'b1000
   } seq_state_type;

endpackage

>>> src/srbm_if.sv
// request and response channel interfaces of the slot ring buffer manager
interface srbm_req_if;
   import srbm_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     cmd;
   logic [IDX_W-1:0]     slot_index;
   logic                 data_valid;
   logic [TS_W-1:0]      timestamp;

   modport source (output valid, output cmd, output slot_index, output data_valid,
                   output timestamp, input ready);
   modport sink   (input valid, input cmd, input slot_index, input data_valid,
                   input timestamp, output ready);
endinterface

interface srbm_rsp_if;
   import srbm_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 ok;
   logic [IDX_W-1:0]     slot;
   logic [TS_W-1:0]      stamp;

   modport source (output valid, output ok, output slot, output stamp, input ready);
   modport sink   (input valid, input ok, input slot, input stamp, output ready);
endinterface

>>> src/srbm_ram.sv
// generic single write, single read ram with registered read data
module srbm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/slot_ring_buffer_manager_top.sv
// top level of the slot ring buffer manager: slot ownership sequencer and timestamp store
//
// Hands ring buffer slots between one producer and one consumer. Each request transaction
// (put-acquire, put-done, get-acquire, get-done, clear) yields exactly one response
// transaction carrying ok, the granted slot and, for a granted get, the stored timestamp.
// A small sequencer runs each command through a single read/modify/write port on the slot
// state table: the block takes a transaction in SEQ_IDLE, executes it in SEQ_EXEC and
// loads the response register in SEQ_DONE once that register is free. A granted get in
// latest mode without overwrite also walks backward through the ring one slot per cycle
// in SEQ_WALK before SEQ_DONE, freeing the run of full slots behind the granted one: at
// most n - 2 slots for an active slot count n of two or more, none for a one-slot ring.
// The request side is not ready while a transaction is in progress; a finished response
// waits in its output register while the next request is taken. Timestamps live in a ram
// with a registered read. Configuration is written through the csr port; the user must
// write it only while the block is idle, as the block itself does not enforce this.
module slot_ring_buffer_manager_top #(
   parameter int NUM_SLOTS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   srbm_req_if.sink                         req_chan,
   srbm_rsp_if.source                       rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [srbm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [srbm_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import srbm_pkg::*;

   localparam int PW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int XW = ((PW > CNT_W) ? PW : CNT_W) + 1;

   // configuration registers
   logic             latest_ff;
   logic             overwrite_ff;
   logic [CNT_W-1:0] slot_count_ff;

   // sequencer and command registers
   seq_state_type    seq_ff, seq_in;
   logic [CMD_W-1:0] cmd_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             dvalid_ff;
   logic [TS_W-1:0]  ts_ff;
   logic [PW-1:0]    addr_ff, addr_in;

   // ring pointers
   logic [PW-1:0]    write_ptr_ff, write_ptr_in;
   logic [PW-1:0]    read_ptr_ff, read_ptr_in;
   logic [PW-1:0]    last_put_ff, last_put_in;
   logic [PW-1:0]    last_get_ff, last_get_in;

   // backward walk
   logic [PW-1:0]    walk_i_ff, walk_i_in;
   logic [PW-1:0]    walk_end_ff, walk_end_in;
   logic [XW-1:0]    walk_cnt_ff, walk_cnt_in;

   // result of the command in flight
   logic             ok_ff, ok_in;
   logic [PW-1:0]    grant_ff, grant_in;
   logic             stamp_sel_ff, stamp_sel_in;

   // response register
   logic             rsp_valid_ff;
   logic             rsp_ok_ff;
   logic [IDX_W-1:0] rsp_slot_ff;
   logic [TS_W-1:0]  rsp_stamp_ff;

   // slot state table, one read and one write port
   slot_state_type   slot_state_ff [NUM_SLOTS];
   logic [PW-1:0]    st_raddr;
   slot_state_type   st_rdata;
   logic             st_we;
   logic [PW-1:0]    st_waddr;
   slot_state_type   st_wdata;
   logic             st_clear;

   // timestamp ram ports
   logic             ram_we;
   logic             ram_re;
   logic [TS_W-1:0]  ram_rdata;

   // derived values
   logic [XW-1:0]    cnt_x;
   logic [XW-1:0]    n_cur;
   logic [PW-1:0]    eff_w;
   logic [PW-1:0]    eff_r;
   logic [XW-1:0]    idx_x;
   logic [XW-1:0]    eff_w_inc;
   logic [XW-1:0]    addr_inc;
   logic [PW-1:0]    n_last;
   logic [PW-1:0]    addr_dec;
   logic [PW-1:0]    walk_dec;
   logic             req_fire;
   logic             rsp_free;

   // active slot count and effective pointers
   always_comb begin
      cnt_x = XW'(slot_count_ff);
      if (cnt_x == '0) begin
         n_cur = XW'(1);
      end else if (cnt_x > XW'(NUM_SLOTS)) begin
         n_cur = XW'(NUM_SLOTS);
      end else begin
         n_cur = cnt_x;
      end
      eff_w     = (XW'(write_ptr_ff) < n_cur) ? write_ptr_ff : '0;
      eff_r     = (XW'(read_ptr_ff) < n_cur) ? read_ptr_ff : '0;
      idx_x     = XW'(idx_ff);
      eff_w_inc = XW'(eff_w) + XW'(1);
      addr_inc  = XW'(addr_ff) + XW'(1);
      n_last    = PW'(n_cur - XW'(1));
      addr_dec  = (addr_ff == '0) ? n_last : addr_ff - PW'(1);
      walk_dec  = (walk_i_ff == '0) ? n_last : walk_i_ff - PW'(1);
   end

   // handshakes
   assign req_chan.ready = (seq_ff == SEQ_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   // state table read port follows the walk index while walking
   assign st_raddr = (seq_ff == SEQ_WALK) ? walk_i_ff : addr_ff;
   assign st_rdata = slot_state_ff[st_raddr];

   // sequencer next state and command execution
   always_comb begin
      seq_in       = seq_ff;
      addr_in      = addr_ff;
      write_ptr_in = write_ptr_ff;
      read_ptr_in  = read_ptr_ff;
      last_put_in  = last_put_ff;
      last_get_in  = last_get_ff;
      walk_i_in    = walk_i_ff;
      walk_end_in  = walk_end_ff;
      walk_cnt_in  = walk_cnt_ff;
      ok_in        = ok_ff;
      grant_in     = grant_ff;
      stamp_sel_in = stamp_sel_ff;
      st_we        = 1'b0;
      st_waddr     = addr_ff;
      st_wdata     = SLOT_FREE;
      st_clear     = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;

      unique case (seq_ff)
         SEQ_IDLE: begin
            if (req_fire) begin
               // pick the slot the command works on
               case (req_chan.cmd)
                  CMD_PUT_ACQUIRE: addr_in = eff_w;
                  CMD_GET_ACQUIRE: addr_in = eff_r;
                  default:         addr_in = PW'(XW'(req_chan.slot_index));
               endcase
               ok_in        = 1'b0;
               grant_in     = '0;
               stamp_sel_in = 1'b0;
               seq_in       = SEQ_EXEC;
            end
         end

         SEQ_EXEC: begin
            seq_in = SEQ_DONE;
            unique case (cmd_ff)
               CMD_PUT_ACQUIRE: begin
                  if (!(st_rdata == SLOT_READING ||
                        (!overwrite_ff && st_rdata != SLOT_FREE))) begin
                     ram_we      = 1'b1;
                     st_we       = 1'b1;
                     st_wdata    = SLOT_WRITING;
                     last_put_in = addr_ff;
                     ok_in       = 1'b1;
                     grant_in    = addr_ff;
                  end
               end
               CMD_PUT_DONE: begin
                  if (idx_x < n_cur && addr_ff == last_put_ff &&
                      st_rdata == SLOT_WRITING) begin
                     st_we = 1'b1;
                     ok_in = 1'b1;
                     if (dvalid_ff) begin
                        st_wdata     = SLOT_FULL;
                        write_ptr_in = (eff_w_inc >= n_cur) ? '0 : PW'(eff_w_inc);
                        if (latest_ff) begin
                           read_ptr_in = addr_ff;
                        end
                     end
                  end
               end
               CMD_GET_ACQUIRE: begin
                  if (st_rdata == SLOT_FULL) begin
                     ram_re       = 1'b1;
                     st_we        = 1'b1;
                     st_wdata     = SLOT_READING;
                     last_get_in  = addr_ff;
                     ok_in        = 1'b1;
                     grant_in     = addr_ff;
                     stamp_sel_in = 1'b1;
                     if (latest_ff) begin
                        if (!overwrite_ff) begin
                           walk_i_in   = addr_dec;
                           walk_end_in = (addr_inc >= n_cur) ? '0 : PW'(addr_inc);
                           walk_cnt_in = '0;
                           seq_in      = SEQ_WALK;
                        end
                     end else begin
                        read_ptr_in = (addr_inc >= n_cur) ? '0 : PW'(addr_inc);
                     end
                  end
               end
               CMD_GET_DONE: begin
                  if (idx_x < n_cur && addr_ff == last_get_ff) begin
                     st_we    = 1'b1;
                     st_wdata = SLOT_FREE;
                     ok_in    = 1'b1;
                  end
               end
               CMD_CLEAR: begin
                  st_clear     = 1'b1;
                  write_ptr_in = '0;
                  read_ptr_in  = '0;
                  last_put_in  = '0;
                  last_get_in  = '0;
                  ok_in        = 1'b1;
               end
               default: begin
                  ok_in = 1'b0;
               end
            endcase
         end

         SEQ_WALK: begin
            // free one full slot per cycle going backward
            if (walk_cnt_ff < n_cur && walk_i_ff != walk_end_ff &&
                st_rdata == SLOT_FULL) begin
               st_we       = 1'b1;
               st_waddr    = walk_i_ff;
               st_wdata    = SLOT_FREE;
               walk_i_in   = walk_dec;
               walk_cnt_in = walk_cnt_ff + XW'(1);
            end else begin
               seq_in = SEQ_DONE;
            end
         end

         SEQ_DONE: begin
            if (rsp_free) begin
               seq_in = SEQ_IDLE;
            end
         end

         default: begin
            seq_in = SEQ_IDLE;
         end
      endcase
   end

   // sequencer and pointer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SEQ_IDLE;
         write_ptr_ff <= '0;
         read_ptr_ff  <= '0;
         last_put_ff  <= '0;
         last_get_ff  <= '0;
      end else begin
         seq_ff       <= seq_in;
         write_ptr_ff <= write_ptr_in;
         read_ptr_ff  <= read_ptr_in;
         last_put_ff  <= last_put_in;
         last_get_ff  <= last_get_in;
      end
   end

   // command payload and working registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff    <= req_chan.cmd;
         idx_ff    <= req_chan.slot_index;
         dvalid_ff <= req_chan.data_valid;
         ts_ff     <= req_chan.timestamp;
      end
      addr_ff      <= addr_in;
      walk_i_ff    <= walk_i_in;
      walk_end_ff  <= walk_end_in;
      walk_cnt_ff  <= walk_cnt_in;
      ok_ff        <= ok_in;
      grant_ff     <= grant_in;
      stamp_sel_ff <= stamp_sel_in;
   end

   // slot state table
   always_ff @(posedge clock) begin
      if (reset || st_clear) begin
         for (int k = 0; k < NUM_SLOTS; k++) begin
            slot_state_ff[k] <= SLOT_FREE;
         end
      end else if (st_we) begin
         slot_state_ff[st_waddr] <= st_wdata;
      end
   end

   // timestamp store
   srbm_ram #(
      .WIDTH (TS_W),
      .DEPTH (NUM_SLOTS)
   ) u_time_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr_ff),
      .wr_data (ts_ff),
      .rd_en   (ram_re),
      .rd_addr (addr_ff),
      .rd_data (ram_rdata)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (seq_ff == SEQ_DONE && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_ff == SEQ_DONE && rsp_free) begin
         rsp_ok_ff    <= ok_ff;
         rsp_slot_ff  <= IDX_W'(XW'(grant_ff));
         rsp_stamp_ff <= stamp_sel_ff ? ram_rdata : '0;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.ok    = rsp_ok_ff;
   assign rsp_chan.slot  = rsp_slot_ff;
   assign rsp_chan.stamp = rsp_stamp_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         latest_ff     <= 1'b0;
         overwrite_ff  <= 1'b0;
         slot_count_ff <= SLOT_COUNT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LATEST_MODE:  latest_ff     <= csr_wr_data[0];
            CSR_OVERWRITE_EN: overwrite_ff  <= csr_wr_data[0];
            CSR_SLOT_COUNT:   slot_count_ff <= csr_wr_data;
            default: begin
               latest_ff <= latest_ff;
            end
         endcase
      end
   end

endmodule
